### design/wtst_pkg.sv
`default_nettype none

package wtst_pkg;

  // Fixed field widths of one slot boundary
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;
  localparam int MOD_W  = 11;   // minute-of-day, up to 31*60+63

  // Time constants
  localparam logic [HOUR_W-1:0] LAST_HOUR   = 5'd23;
  localparam logic [MIN_W-1:0]  LAST_MINUTE = 6'd59;
  localparam logic [MIN_W-1:0]  HALF_PAST   = 6'd30;
  localparam logic [MIN_W-1:0]  BEFORE_HALF = 6'd29;
  localparam logic [MOD_W-1:0]  MIN_PER_HOUR = 11'd60;

  // Operation codes
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  // Status codes
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2
  } status_t;

  // One time slot
  typedef struct packed {
    logic [HOUR_W-1:0] sh;
    logic [MIN_W-1:0]  sm;
    logic [HOUR_W-1:0] eh;
    logic [MIN_W-1:0]  em;
  } slot_t;

  // Control group broadcast from the sequencer to every cell
  typedef struct packed {
    logic              load;     // capture the selected day's slot
    logic              add_go;   // commit a split
    logic              rem_go;   // commit a merge
    logic [HOUR_W-1:0] new_sh;   // start of the new slot
    logic [MIN_W-1:0]  new_sm;
    logic [HOUR_W-1:0] cut_eh;   // new end of the split slot
    logic [MIN_W-1:0]  cut_em;
  } cell_ctrl_t;

  // Minute of day: h*60 + m
  function automatic logic [MOD_W-1:0] day_minute(input logic [HOUR_W-1:0] h,
                                                   input logic [MIN_W-1:0] m);
    day_minute = MOD_W'(h) * MIN_PER_HOUR + MOD_W'(m);
  endfunction

endpackage

`default_nettype wire

### design/wtst_cell.sv
`default_nettype none

// One slot position for all days. Shifts take the neighbor's captured entry.
module wtst_cell #(
  parameter int DAYS  = 7,
  parameter int IDX   = 0,
  parameter int DAY_W = 3,
  parameter int SLOT_W = 2
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire wtst_pkg::cell_ctrl_t      ctrl,
  input  wire [DAY_W-1:0]                day,
  input  wire [SLOT_W-1:0]               slot,
  input  wire [wtst_pkg::MOD_W-1:0]      tmod,
  input  wire wtst_pkg::slot_t           left_i,
  input  wire wtst_pkg::slot_t           right_i,
  output wtst_pkg::slot_t                rd_o,
  output logic                           hit_o
);

  localparam logic [SLOT_W:0] K = (SLOT_W + 1)'(IDX);

  wtst_pkg::slot_t mem_r [DAYS];
  wtst_pkg::slot_t rd_r;
  wtst_pkg::slot_t slot_nxt;
  logic [SLOT_W:0] s_ext;
  logic [wtst_pkg::MOD_W-1:0] a_mod, b_mod;

  assign s_ext = {1'b0, slot};
  assign rd_o  = rd_r;

  // Range test on the captured entry
  assign a_mod = wtst_pkg::day_minute(rd_r.sh, rd_r.sm);
  assign b_mod = wtst_pkg::day_minute(rd_r.eh, rd_r.em);
  assign hit_o = (tmod >= a_mod) && (tmod <= b_mod);

  // New value of this position after a split or a merge
  always_comb begin
    slot_nxt = rd_r;
    if (ctrl.add_go) begin
      if (K == s_ext) begin
        slot_nxt.eh = ctrl.cut_eh;
        slot_nxt.em = ctrl.cut_em;
      end else if (K == s_ext + 1'b1) begin
        slot_nxt.sh = ctrl.new_sh;
        slot_nxt.sm = ctrl.new_sm;
        slot_nxt.eh = left_i.eh;
        slot_nxt.em = left_i.em;
      end else if (K > s_ext + 1'b1) begin
        slot_nxt = left_i;
      end
    end else if (ctrl.rem_go) begin
      if (K + 1'b1 == s_ext) begin
        slot_nxt.eh = right_i.eh;
        slot_nxt.em = right_i.em;
      end else if (K >= s_ext) begin
        slot_nxt = right_i;
      end
    end
  end

  // Per-day storage and read capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < DAYS; d++) begin
        mem_r[d].sh <= '0;
        mem_r[d].sm <= '0;
        mem_r[d].eh <= (IDX == 0) ? wtst_pkg::LAST_HOUR : '0;
        mem_r[d].em <= (IDX == 0) ? wtst_pkg::LAST_MINUTE : '0;
      end
    end else if (ctrl.add_go || ctrl.rem_go) begin
      mem_r[day] <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rd_r <= mem_r[day];
    end
  end

endmodule

`default_nettype wire

### design/weekly_time_slot_table_top.sv
// Sequence: an accepted transaction passes through S_LOAD, which captures the
// day's slots, and S_EXEC, which updates the cell row and registers the result;
// S_DONE then holds out_valid until out_ready. No new transaction is accepted
// until the result has been taken.
// Reset (synchronous, rst_n low): every day holds one slot 00:00-23:59,
// no result is pending and the block is ready for input.
`default_nettype none

module weekly_time_slot_table_top #(
  parameter int DAYS          = 7,
  parameter int SLOTS_PER_DAY = 4
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     in_valid,
  output logic                                    in_ready,
  input  wire  [1:0]                              in_operation,
  input  wire  [2:0]                              in_weekday,
  input  wire  [$clog2(SLOTS_PER_DAY)-1:0]        in_slot,
  input  wire  [4:0]                              in_hour,
  input  wire  [5:0]                              in_minute,
  output logic                                    out_valid,
  input  wire                                     out_ready,
  output logic [1:0]                              out_status,
  output logic [$clog2(SLOTS_PER_DAY + 1)-1:0]    out_slot_index,
  output logic [$clog2(SLOTS_PER_DAY + 1)-1:0]    out_slot_count
);

  localparam int SLOT_W = $clog2(SLOTS_PER_DAY);
  localparam int CNT_W  = $clog2(SLOTS_PER_DAY + 1);
  localparam int DAY_W = (DAYS > 1) ? $clog2(DAYS) : 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS_PER_DAY);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_EXEC = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Captured transaction
  logic [1:0]        op_r;
  logic [2:0]        day_r;
  logic [SLOT_W-1:0] slot_r;
  logic [4:0]        hour_r;
  logic [5:0]        min_r;
  logic [wtst_pkg::MOD_W-1:0] tmod_r;

  logic [CNT_W-1:0]  cnt_r [DAYS];
  logic [1:0]        status_r, status_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  ocnt_r, ocnt_nxt;

  wtst_pkg::cell_ctrl_t ctrl;
  wtst_pkg::slot_t      rd   [SLOTS_PER_DAY];
  wtst_pkg::slot_t      lnb  [SLOTS_PER_DAY];
  wtst_pkg::slot_t      rnb  [SLOTS_PER_DAY];
  logic [SLOTS_PER_DAY-1:0] hit;

  wtst_pkg::slot_t  cur;
  logic             day_ok;
  logic [DAY_W-1:0] day_idx;
  logic [CNT_W-1:0] n;
  logic [CNT_W:0]   s_cnt;
  logic             same;
  logic [5:0]       hsum;
  logic [4:0]       mid;
  logic             add_ok, rem_ok;

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = (state_r == S_DONE);
  assign out_status     = status_r;
  assign out_slot_index = idx_r;
  assign out_slot_count = ocnt_r;

  assign day_ok  = (day_r < 3'(DAYS));
  assign day_idx = day_r[DAY_W-1:0];
  assign n       = cnt_r[day_idx];
  assign s_cnt   = (CNT_W + 1)'(slot_r);

  // Row of cells, each handing its captured slot to each of its neighbors
  for (genvar k = 0; k < SLOTS_PER_DAY; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign lnb[k] = '0;
    end else begin : g_left
      assign lnb[k] = rd[k-1];
    end
    if (k == SLOTS_PER_DAY - 1) begin : g_last
      assign rnb[k] = '0;
    end else begin : g_right
      assign rnb[k] = rd[k+1];
    end

    wtst_cell #(
      .DAYS   (DAYS),
      .IDX    (k),
      .DAY_W  (DAY_W),
      .SLOT_W (SLOT_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .day     (day_idx),
      .slot    (slot_r),
      .tmod    (tmod_r),
      .left_i  (lnb[k]),
      .right_i (rnb[k]),
      .rd_o    (rd[k]),
      .hit_o   (hit[k])
    );
  end

  // Slot addressed by the transaction
  always_comb begin
    cur = '0;
    for (int k = 0; k < SLOTS_PER_DAY; k++) begin
      if (slot_r == SLOT_W'(k)) cur = rd[k];
    end
  end

  // Split point
  assign same = (cur.sh == cur.eh);
  assign hsum = {1'b0, cur.sh} + {1'b0, cur.eh};
  assign mid  = hsum[5:1];

  // Decide status, result and cell commands
  always_comb begin
    status_nxt   = wtst_pkg::STAT_OK;
    idx_nxt      = '0;
    ocnt_nxt     = '0;
    add_ok       = 1'b0;
    rem_ok       = 1'b0;
    ctrl         = '0;
    ctrl.load    = (state_r == S_LOAD);
    ctrl.new_sh  = same ? cur.sh : mid;
    ctrl.new_sm  = same ? wtst_pkg::HALF_PAST : '0;
    ctrl.cut_eh  = same ? cur.sh : mid - 5'd1;
    ctrl.cut_em  = same ? wtst_pkg::BEFORE_HALF : wtst_pkg::LAST_MINUTE;

    if (!day_ok) begin
      status_nxt = wtst_pkg::STAT_BAD;
    end else begin
      ocnt_nxt = n;
      case (op_r)
        wtst_pkg::OP_ADD: begin
          if (s_cnt >= {1'b0, n}) begin
            status_nxt = wtst_pkg::STAT_BAD;
          end else if (n >= FULL_CNT) begin
            status_nxt = wtst_pkg::STAT_FULL;
          end else if (same) begin
            if (cur.sm > wtst_pkg::BEFORE_HALF || cur.em < wtst_pkg::HALF_PAST) begin
              status_nxt = wtst_pkg::STAT_BAD;
            end else begin
              add_ok = 1'b1;
            end
          end else if ({1'b0, cur.eh} < {1'b0, cur.sh} + 6'd2) begin
            status_nxt = wtst_pkg::STAT_BAD;
          end else begin
            add_ok = 1'b1;
          end
          if (add_ok) ocnt_nxt = n + 1'b1;
        end
        wtst_pkg::OP_REMOVE: begin
          if (slot_r == '0 || s_cnt >= {1'b0, n}) begin
            status_nxt = wtst_pkg::STAT_BAD;
          end else begin
            rem_ok   = 1'b1;
            ocnt_nxt = n - 1'b1;
          end
        end
        wtst_pkg::OP_LOOKUP: begin
          idx_nxt = n;
          for (int k = SLOTS_PER_DAY - 1; k >= 0; k--) begin
            if (hit[k] && CNT_W'(k) < n) idx_nxt = CNT_W'(k);
          end
        end
        default: begin
          status_nxt = wtst_pkg::STAT_BAD;
        end
      endcase
    end

    ctrl.add_go = add_ok && (state_r == S_EXEC);
    ctrl.rem_go = rem_ok && (state_r == S_EXEC);
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_DONE;
      S_DONE: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Slot counts per day
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < DAYS; d++) cnt_r[d] <= CNT_W'(1);
    end else if (ctrl.add_go || ctrl.rem_go) begin
      cnt_r[day_idx] <= ocnt_nxt;
    end
  end

  // Transaction capture, minute of day, result register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= in_operation;
      day_r  <= in_weekday;
      slot_r <= in_slot;
      hour_r <= in_hour;
      min_r  <= in_minute;
    end
    if (state_r == S_LOAD) begin
      tmod_r <= wtst_pkg::day_minute(hour_r, min_r);
    end
    if (state_r == S_EXEC) begin
      status_r <= status_nxt;
      idx_r    <= idx_nxt;
      ocnt_r   <= ocnt_nxt;
    end
  end

endmodule

`default_nettype wire
